>>> rtl/base64_stream_encoder_unit_defines.svh
// Assertion macros for the base64 stream encoder RTL.
`ifndef BASE64_STREAM_ENCODER_UNIT_DEFINES_SVH
`define BASE64_STREAM_ENCODER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Checked outside reset only.
`define B64E_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("base64 encoder assertion failed");
// Checked at every edge, reset included.
`define B64E_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("base64 encoder assertion failed");
`else
`define B64E_ASSERT(lbl, clk, rstn, prop)
`define B64E_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> rtl/b64e_pkg.sv
// Types, character constants and the alphabet lookup of the base64 encoder.
package b64e_pkg;

  typedef logic [7:0] char_t;

  // Up to four characters produced by one input byte, before URL escaping.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [2:0]      cnt;
  } group_t;

  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_SLASH = 8'h2F;
  localparam char_t CH_PAD   = 8'h3D;
  localparam char_t CH_PCT   = 8'h25;
  localparam char_t CH_TWO   = 8'h32;
  localparam char_t CH_THREE = 8'h33;
  localparam char_t CH_B     = 8'h42;
  localparam char_t CH_D     = 8'h44;
  localparam char_t CH_F     = 8'h46;

  localparam char_t CH_UPPER_A = 8'h41;
  localparam char_t CH_LOWER_A = 8'h61;
  localparam char_t CH_DIGIT_0 = 8'h30;

  function automatic char_t b64_char(input logic [5:0] v);
    char_t c;
    if (v < 6'd26) begin
      c = CH_UPPER_A + {2'b00, v};
    end else if (v < 6'd52) begin
      c = CH_LOWER_A + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = CH_DIGIT_0 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = CH_PLUS;
    end else begin
      c = CH_SLASH;
    end
    return c;
  endfunction

endpackage

>>> rtl/b64e_emit.sv
// Character group register and output serializer with percent escaping.
`include "base64_stream_encoder_unit_defines.svh"

module b64e_emit
  import b64e_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       url_mode_i,
  input  logic       load_i,
  input  group_t     group_i,
  output logic       free_o,
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o,   // out_char
  output logic       m_tlast_o    // run_end
);

  logic       valid_q, valid_d;
  logic [1:0] ci_q, ci_d;
  logic [1:0] si_q, si_d;
  group_t     grp_q;

  char_t cur;
  char_t esc_char;
  logic  esc;
  logic  char_done;
  logic  item_last;
  logic  xfer;

  assign cur = grp_q.chars[ci_q];
  assign esc = url_mode_i && (cur == CH_PLUS || cur == CH_SLASH || cur == CH_PAD);

  always_comb begin
    unique case (si_q)
      2'd0:    esc_char = CH_PCT;
      2'd1:    esc_char = (cur == CH_PAD) ? CH_THREE : CH_TWO;
      2'd2:    esc_char = (cur == CH_PLUS) ? CH_B : ((cur == CH_SLASH) ? CH_F : CH_D);
      default: esc_char = CH_PCT;
    endcase
  end

  assign char_done = !esc || (si_q == 2'd2);
  assign item_last = char_done && (({1'b0, ci_q} + 3'd1) == grp_q.cnt);
  assign xfer      = valid_q && m_tready_i;

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = esc ? esc_char : cur;
  assign m_tlast_o  = item_last;
  // A new group may load in the cycle the current one sends its final byte.
  assign free_o     = !valid_q || (m_tready_i && item_last);

  always_comb begin
    valid_d = valid_q;
    ci_d    = ci_q;
    si_d    = si_q;
    if (load_i) begin
      valid_d = 1'b1;
      ci_d    = 2'd0;
      si_d    = 2'd0;
    end else if (xfer) begin
      if (item_last) begin
        valid_d = 1'b0;
      end else if (char_done) begin
        ci_d = ci_q + 2'd1;
        si_d = 2'd0;
      end else begin
        si_d = si_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ci_q    <= 2'd0;
      si_q    <= 2'd0;
    end else begin
      valid_q <= valid_d;
      ci_q    <= ci_d;
      si_q    <= si_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= group_i;
    end
  end

  `B64E_ASSERT(a_ci_in_group, clk_i, rst_ni, valid_q |-> (({1'b0, ci_q}) < grp_q.cnt))
  `B64E_ASSERT(a_sub_only_escape, clk_i, rst_ni, (valid_q && si_q != 2'd0) |-> esc)
  `B64E_ASSERT(a_load_when_free, clk_i, rst_ni, load_i |-> free_o)
  `B64E_ASSERT(a_load_starts, clk_i, rst_ni, load_i |=> (valid_q && ci_q == 2'd0 && si_q == 2'd0))
  `B64E_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !m_tvalid_o)

endmodule

>>> rtl/base64_stream_encoder_unit.sv
// The first character of a byte is offered in the cycle after its input transfer.
// Output: one transfer per cycle while m_tready_i is high; each byte causes 1 to 4
// characters (up to 10 with percent escapes), about 1.33 on average.
// The next byte is taken in the cycle the previous byte's last character transfers.
// Reset (rst_ni low, async) clears the group phase, leftover bits, URL mode and output valid.
module base64_stream_encoder_unit
  import b64e_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,   // url_mode
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic [7:0] s_tdata_i,     // in_byte
  input  logic       s_tlast_i,     // final_byte
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o,     // out_char
  output logic       m_tlast_o      // run_end
);

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  logic       url_mode_q;
  logic [1:0] phase_q, phase_d;
  logic [3:0] left_q, left_d;
  logic [1:0] phase_eff;
  logic       free;
  logic       accept;
  group_t     grp;

  assign accept    = s_tvalid_i && free;
  assign s_tready_o = free;
  assign phase_eff = (phase_q == 2'd3) ? PH_FIRST : phase_q;

  always_comb begin
    grp.chars = {CH_PAD, CH_PAD, CH_PAD, CH_PAD};
    grp.cnt   = 3'd1;
    phase_d   = PH_FIRST;
    left_d    = 4'd0;
    unique case (phase_eff)
      PH_FIRST: begin
        grp.chars[0] = b64_char(s_tdata_i[7:2]);
        phase_d      = PH_SECOND;
        left_d       = {2'b00, s_tdata_i[1:0]};
        if (s_tlast_i) begin
          grp.chars[1] = b64_char({s_tdata_i[1:0], 4'b0000});
          grp.cnt      = 3'd4;
          phase_d      = PH_FIRST;
          left_d       = 4'd0;
        end
      end
      PH_SECOND: begin
        grp.chars[0] = b64_char({left_q[1:0], s_tdata_i[7:4]});
        phase_d      = PH_THIRD;
        left_d       = s_tdata_i[3:0];
        if (s_tlast_i) begin
          grp.chars[1] = b64_char({s_tdata_i[3:0], 2'b00});
          grp.cnt      = 3'd3;
          phase_d      = PH_FIRST;
          left_d       = 4'd0;
        end
      end
      default: begin
        grp.chars[0] = b64_char({left_q, s_tdata_i[7:6]});
        grp.chars[1] = b64_char(s_tdata_i[5:0]);
        grp.cnt      = 3'd2;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      url_mode_q <= 1'b0;
      phase_q    <= PH_FIRST;
      left_q     <= 4'd0;
    end else begin
      if (cfg_we_i) begin
        url_mode_q <= cfg_wdata_i;
      end
      if (accept) begin
        phase_q <= phase_d;
        left_q  <= left_d;
      end
    end
  end

  b64e_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .url_mode_i (url_mode_q),
    .load_i     (accept),
    .group_i    (grp),
    .free_o     (free),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o)
  );

endmodule

>>> dv/base64_stream_encoder_unit_tb.sv
// Self-checking stream testbench for the base64 stream encoder: directed table, then random messages.
`timescale 1ns / 1ps
module base64_stream_encoder_unit_tb
  import b64e_pkg::*;
();

  localparam int unsigned ClkHalf     = 6;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned TailCycles  = 8;
  localparam string       B64Alpha    =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef enum logic {ROW_DATA, ROW_SET_URL} row_kind_e;

  // chars: typed expectation of the row; empty means the encoder model decides
  typedef struct {
    row_kind_e  kind;
    logic [7:0] data;
    logic       last;
    string      chars;
  } dir_row_t;

  typedef struct packed {
    char_t ch;
    logic  run_end;
  } enc_char_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_wdata_i;
  logic       s_tvalid_i;
  logic       s_tready_o;
  logic [7:0] s_tdata_i;
  logic       s_tlast_i;
  logic       m_tvalid_o;
  logic       m_tready_i;
  logic [7:0] m_tdata_o;
  logic       m_tlast_o;

  base64_stream_encoder_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tlast_i   (s_tlast_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tlast_o   (m_tlast_o)
  );

  dir_row_t   dir_tab[$];
  enc_char_t  enc_char_q[$];
  char_t      pend_q[$];
  logic       url_esc    = 1'b0;
  logic [1:0] grp_phase  = 2'd0;
  logic [3:0] carry_bits = 4'd0;
  int         typed_row;
  int         err_cnt    = 0;
  logic       src_gaps   = 1'b1;
  logic       sink_gaps  = 1'b1;
  logic       hold_req   = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Encoder model
  // ---------------------------------------------------------------------------
  function automatic void stash(char_t c);
    pend_q.insert(pend_q.size(), c);
  endfunction

  function automatic void emit(char_t c);
    if (url_esc && (c == CH_PLUS || c == CH_SLASH || c == CH_PAD)) begin
      stash(CH_PCT);
      stash(c == CH_PAD ? CH_THREE : CH_TWO);
      stash(c == CH_PLUS ? CH_B : (c == CH_SLASH ? CH_F : CH_D));
    end else begin
      stash(c);
    end
  endfunction

  function automatic void emit_sextet(logic [5:0] v);
    emit(char_t'(B64Alpha[v]));
  endfunction

  function automatic void encode_byte(logic [7:0] b, logic fin, int row);
    pend_q.delete();
    case (grp_phase)
      2'd1: begin
        emit_sextet({carry_bits[1:0], b[7:4]});
        carry_bits = b[3:0];
        grp_phase  = 2'd2;
      end
      2'd2: begin
        emit_sextet({carry_bits, b[7:6]});
        emit_sextet(b[5:0]);
        carry_bits = 4'd0;
        grp_phase  = 2'd0;
      end
      default: begin
        emit_sextet(b[7:2]);
        carry_bits = {2'b00, b[1:0]};
        grp_phase  = 2'd1;
      end
    endcase
    if (fin) begin
      // flush the partial sextet zero-filled, then pad to four characters
      if (grp_phase == 2'd1) begin
        emit_sextet({carry_bits[1:0], 4'b0000});
        emit(CH_PAD);
        emit(CH_PAD);
      end else if (grp_phase == 2'd2) begin
        emit_sextet({carry_bits, 2'b00});
        emit(CH_PAD);
      end
      grp_phase  = 2'd0;
      carry_bits = 4'd0;
    end
    if (row >= 0 && dir_tab[row].chars.len() > 0) begin
      pend_q.delete();
      for (int i = 0; i < dir_tab[row].chars.len(); i++) stash(dir_tab[row].chars[i]);
    end
    foreach (pend_q[i]) begin
      enc_char_q.insert(enc_char_q.size(), enc_char_t'{pend_q[i], i == pend_q.size() - 1});
    end
  endfunction

  function automatic void check_char(char_t ch, logic re);
    enc_char_t want;
    if (enc_char_q.size() == 0) begin
      $display("%0t: extra transfer: expected none, actual char %h run_end %b", $time, ch, re);
      err_cnt++;
      return;
    end
    want = enc_char_q.pop_front();
    if (want.ch !== ch) begin
      $display("%0t: out_char mismatch: expected %h, actual %h", $time, want.ch, ch);
      err_cnt++;
    end
    if (want.run_end !== re) begin
      $display("%0t: run_end mismatch: expected %b, actual %b", $time, want.run_end, re);
      err_cnt++;
    end
  endfunction

  // Both handshakes and the config write are sampled here, before NBA updates.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) url_esc = cfg_wdata_i;
      if (s_tvalid_i && s_tready_o) encode_byte(s_tdata_i, s_tlast_i, typed_row);
      if (m_tvalid_o && m_tready_i) check_char(m_tdata_o, m_tlast_o);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random backpressure, plus one long hold on request
  // ---------------------------------------------------------------------------
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_tready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        m_tready_i <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(posedge clk_i);
      end else begin
        m_tready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, logic fin, int row);
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= b;
    s_tlast_i  <= fin;
    typed_row  <= row;
    do @(posedge clk_i); while (!s_tready_o);
  endtask

  task automatic wait_drained();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (enc_char_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic write_url(logic v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'hFF;
      1:       return 8'h00;
      2:       return {5'b11111, 3'($urandom)};  // plus or slash in the top sextet
      3:       return {2'($urandom), 6'b111110 | 6'($urandom_range(0, 1))};
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic run_messages(int unsigned n_items);
    int unsigned sent = 0;
    int unsigned len;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      for (int unsigned k = 1; k <= len; k++) send_byte(pick_byte(), k == len, -1);
      sent += len;
    end
  endtask

  task automatic add_row(row_kind_e k, logic [7:0] d, logic l, string s);
    dir_tab.insert(dir_tab.size(), dir_row_t'{k, d, l, s});
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    s_tvalid_i  = 1'b0;
    s_tdata_i   = 8'h00;
    s_tlast_i   = 1'b0;
    m_tready_i  = 1'b0;
    typed_row   = -1;

    add_row(ROW_SET_URL, 8'h00, 1'b0, "");
    add_row(ROW_DATA,    8'h00, 1'b1, "AA==");
    add_row(ROW_DATA,    8'hFF, 1'b1, "/w==");
    add_row(ROW_DATA,    8'hFF, 1'b0, "/");
    add_row(ROW_DATA,    8'hFF, 1'b0, "/");
    add_row(ROW_DATA,    8'hFF, 1'b1, "//");
    add_row(ROW_DATA,    8'h00, 1'b0, "A");
    add_row(ROW_DATA,    8'h00, 1'b1, "AA=");
    add_row(ROW_DATA,    8'hF8, 1'b1, "+A==");
    add_row(ROW_DATA,    8'h4D, 1'b0, "");
    add_row(ROW_DATA,    8'h61, 1'b0, "");
    add_row(ROW_DATA,    8'h6E, 1'b1, "");
    add_row(ROW_DATA,    8'h00, 1'b0, "");
    add_row(ROW_DATA,    8'hFF, 1'b1, "");
    add_row(ROW_SET_URL, 8'h01, 1'b0, "");
    add_row(ROW_DATA,    8'hFF, 1'b1, "%2Fw%3D%3D");
    add_row(ROW_DATA,    8'hF8, 1'b1, "%2BA%3D%3D");
    add_row(ROW_DATA,    8'h00, 1'b1, "AA%3D%3D");
    add_row(ROW_DATA,    8'hFB, 1'b0, "");
    add_row(ROW_DATA,    8'hFF, 1'b0, "");
    add_row(ROW_DATA,    8'hFF, 1'b1, "");
    add_row(ROW_DATA,    8'h00, 1'b0, "A");
    add_row(ROW_DATA,    8'h00, 1'b1, "AA%3D");
    add_row(ROW_SET_URL, 8'h00, 1'b0, "");
    add_row(ROW_DATA,    8'h3E, 1'b1, "");

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_SET_URL) write_url(dir_tab[i].data[0]);
      else send_byte(dir_tab[i].data, dir_tab[i].last, i);
    end

    // escapes on; receiver holds off while the sender keeps pushing
    write_url(1'b1);
    hold_req = 1'b1;
    run_messages(55);
    wait_drained();
    run_messages(55);

    write_url(1'b0);
    run_messages(110);

    write_url(1'b1);
    run_messages(100);

    // no idling on either side for the closing stretch
    write_url(1'b0);
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    run_messages(90);

    wait_drained();
    if (err_cnt == 0) begin
      $display("** base64_stream_encoder_unit: PASSED **");
    end else begin
      $display("** base64_stream_encoder_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("** base64_stream_encoder_unit: FAILED **");
    $finish;
  end

endmodule
